// ===== design/font_name_pattern_matcher_assert.svh =====
// Assertion macros for the font name pattern matcher.
`ifndef FONT_NAME_PATTERN_MATCHER_ASSERT_SVH
`define FONT_NAME_PATTERN_MATCHER_ASSERT_SVH

// Checked only while out of reset.
`define FNPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define FNPM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/fnpm_pkg.sv =====
// Package: pattern table and sizing constants for the font name pattern matcher.
package fnpm_pkg;

  localparam int KEY_BUFFER_DEF = 64;
  localparam int WINDOW_DEF     = 16;

  localparam int NUM_PATTERNS = 23;
  localparam int PAT_MAX      = 16;
  localparam int ROW_W        = 5;
  localparam int FONT_W       = 3;
  localparam int LEN_W        = 5;

  typedef logic [PAT_MAX*8-1:0] pat_text_t;

  // Right-justified text: byte k holds the k-th character from the end.
  localparam pat_text_t PAT_TEXT [NUM_PATTERNS] = '{
    "swis721", "dutch801", "monospac821", "bankgothic", "bgoth",
    "commercialscript", "commscript", "comscr", "vineta",
    "commercialpi", "commpi", "universalmath", "univmath",
    "stylus", "stylu", "isocpeur", "isocteur", "isoct", "isocp",
    "romans", "romant", "swiss", "txt"
  };

  localparam logic [LEN_W-1:0] PAT_LEN [NUM_PATTERNS] = '{
    5'd7, 5'd8, 5'd11, 5'd10, 5'd5, 5'd16, 5'd10, 5'd6, 5'd6,
    5'd12, 5'd6, 5'd13, 5'd8, 5'd6, 5'd5, 5'd8, 5'd8, 5'd5, 5'd5,
    5'd6, 5'd6, 5'd5, 5'd3
  };

  localparam logic [FONT_W-1:0] PAT_FONT [NUM_PATTERNS] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd6, 3'd6, 3'd7, 3'd7, 3'd0, 3'd1, 3'd1, 3'd0,
    3'd0, 3'd1, 3'd0, 3'd2
  };

endpackage

// ===== design/font_name_pattern_matcher.sv =====
// Top level: streaming font name matcher against a fixed pattern table.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one request per byte of a
//   font name: char_code_i, has_char_i (byte present) and last_i (final item).
//   Bytes are case folded; only letters and digits are kept, at most
//   KEY_BUFFER-1 of them. Each kept byte enters a WINDOW deep history whose
//   tail is compared against all 23 patterns at once.
//   Output channel (out_valid_o / out_ready_i) carries one request per name,
//   produced by the item with last_i set: found_o, row_index_o (lowest
//   pattern seen) and host_font_o. Not found gives all zero fields.
// Timing:
//   One item per cycle while no last item waits for a result slot. An item
//   lands in the input register at the accepting edge; the match/update
//   stage then loads the result register, once the result slot is free,
//   raising out_valid_o. The one-item-per-cycle rate is set by the match
//   stage, which updates history and seen bits for one byte per clock.
// Reset and stalls:
//   rst_ni clears history, seen bits, count and both valid flags.
//   While a result waits, non-last items keep streaming; a second last item
//   waits in the input register, and only then does in_ready_o drop.
`include "font_name_pattern_matcher_assert.svh"

module font_name_pattern_matcher
  import fnpm_pkg::*;
#(
  parameter int KEY_BUFFER = KEY_BUFFER_DEF,
  parameter int WINDOW     = WINDOW_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        char_code_i,
  input  logic              has_char_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              found_o,
  output logic [ROW_W-1:0]  row_index_o,
  output logic [FONT_W-1:0] host_font_o
);

  localparam int CNT_W = $clog2(KEY_BUFFER);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(KEY_BUFFER - 1);

  // Input register.
  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_has_q;
  logic       s1_last_q;

  // Name state.
  logic [7:0]              hist_q [WINDOW];
  logic [7:0]              hist_d [WINDOW];
  logic [NUM_PATTERNS-1:0] seen_q, seen_d, hits;
  logic [CNT_W-1:0]        cnt_q, cnt_d;

  // Result register.
  logic              out_valid_q;
  logic              found_q;
  logic [ROW_W-1:0]  row_q;
  logic [FONT_W-1:0] font_q;

  logic              out_free, advance;
  logic [7:0]        folded;
  logic              keep;
  logic              found_d;
  logic [ROW_W-1:0]  row_d;
  logic [FONT_W-1:0] font_d;

  // A last item needs a free result slot; other items always drain.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_char_q <= char_code_i;
      s1_has_q  <= has_char_i;
      s1_last_q <= last_i;
    end
  end

  // Fold case, keep letters/digits, respect the length cap.
  always_comb begin
    folded = s1_char_q;
    if (s1_char_q >= "A" && s1_char_q <= "Z") begin
      folded = s1_char_q + 8'd32;
    end
    keep = s1_has_q && (cnt_q < CNT_MAX) &&
           ((folded >= "a" && folded <= "z") || (folded >= "0" && folded <= "9"));
  end

  always_comb begin
    hist_d[0] = folded;
    for (int w = 1; w < WINDOW; w++) begin
      hist_d[w] = hist_q[w-1];
    end
  end

  // Tail compare. History beyond the kept count is zero and no pattern
  // holds a zero byte, so no explicit length-vs-count check is needed.
  always_comb begin
    for (int i = 0; i < NUM_PATTERNS; i++) begin
      hits[i] = 1'b1;
      for (int k = 0; k < PAT_MAX; k++) begin
        if (k < int'(PAT_LEN[i]) && hist_d[k] != PAT_TEXT[i][k*8 +: 8]) begin
          hits[i] = 1'b0;
        end
      end
    end
  end

  assign seen_d = keep ? (seen_q | hits) : seen_q;
  assign cnt_d  = keep ? cnt_q + 1'b1 : cnt_q;

  // Lowest seen row wins.
  always_comb begin
    row_d = '0;
    for (int i = NUM_PATTERNS - 1; i >= 0; i--) begin
      if (seen_d[i]) begin
        row_d = ROW_W'(i);
      end
    end
    found_d = |seen_d;
    font_d  = found_d ? PAT_FONT[row_d] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < WINDOW; w++) begin
        hist_q[w] <= '0;
      end
      seen_q <= '0;
      cnt_q  <= '0;
    end else if (advance) begin
      if (s1_last_q) begin
        for (int w = 0; w < WINDOW; w++) begin
          hist_q[w] <= '0;
        end
        seen_q <= '0;
        cnt_q  <= '0;
      end else if (keep) begin
        hist_q <= hist_d;
        seen_q <= seen_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_last_q) begin
      found_q <= found_d;
      row_q   <= row_d;
      font_q  <= font_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign row_index_o = row_q;
  assign host_font_o = font_q;

  `FNPM_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o && !s1_valid_q, "valid during reset")
  `FNPM_ASSERT(a_not_found_zero, out_valid_o && !found_o |-> row_index_o == '0 && host_font_o == '0, "not found with nonzero fields")
  `FNPM_ASSERT(a_cnt_cap, cnt_q <= CNT_MAX, "kept count above cap")
  `FNPM_ASSERT(a_clear_after_last, advance && s1_last_q |=> seen_q == '0 && cnt_q == '0, "state not cleared after name")
  `FNPM_ASSERT(a_result_source, $rose(out_valid_q) |-> $past(advance && s1_last_q), "result without last item")

endmodule

// ===== tb/font_name_pattern_matcher_tb.sv =====
`timescale 1ns / 1ps
// Testbench for font_name_pattern_matcher: directed names, then random names checked against a predictor.
module font_name_pattern_matcher_tb
  import fnpm_pkg::*;
;

  // Sizing of the name key and the history window.
  localparam int KEPT_MAX   = 63;
  localparam int WINDOW_LEN = 16;
  localparam int NUM_ROWS   = 23;

  // Rows used by the directed names.
  localparam logic [ROW_W-1:0] ROW_ISOCP = 5'd18;
  localparam logic [ROW_W-1:0] ROW_TXT   = 5'd22;

  // Substitute font classes, in the order the block codes them.
  typedef enum logic [FONT_W-1:0] {
    FONT_SANS, FONT_SERIF, FONT_MONO, FONT_DISPLAY,
    FONT_SCRIPT, FONT_SYMBOL, FONT_MATH, FONT_MARKER
  } host_font_e;

  typedef struct packed {
    logic               found;
    logic [ROW_W-1:0]   row;
    logic [FONT_W-1:0]  font;
  } match_t;

  // One directed request; typed marks rows whose result is written out here.
  typedef struct packed {
    logic [7:0]        code;
    logic              has;
    logic              lst;
    logic              typed;
    logic              found;
    logic [ROW_W-1:0]  row;
    host_font_e        font;
  } probe_t;

  // Pattern table, lowest row wins.
  string pat_text [NUM_ROWS] = '{
    "swis721", "dutch801", "monospac821", "bankgothic", "bgoth",
    "commercialscript", "commscript", "comscr", "vineta",
    "commercialpi", "commpi", "universalmath", "univmath",
    "stylus", "stylu", "isocpeur", "isocteur", "isoct", "isocp",
    "romans", "romant", "swiss", "txt"
  };

  localparam host_font_e PAT_FONT [NUM_ROWS] = '{
    FONT_SANS, FONT_SERIF, FONT_MONO, FONT_DISPLAY, FONT_DISPLAY,
    FONT_SCRIPT, FONT_SCRIPT, FONT_SCRIPT, FONT_SCRIPT,
    FONT_SYMBOL, FONT_SYMBOL, FONT_MATH, FONT_MATH,
    FONT_MARKER, FONT_MARKER, FONT_SANS, FONT_SERIF, FONT_SERIF, FONT_SANS,
    FONT_SANS, FONT_SERIF, FONT_SANS, FONT_MONO
  };

  // Directed names: empty name, case folding, punctuation only, a byteless
  // terminator, character extremes with no hit, and a short pattern that
  // shares its head with a longer one.
  localparam int NUM_PROBES = 23;
  localparam probe_t PROBES [NUM_PROBES] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 5'd0,    FONT_SANS},
    '{"T",   1'b1, 1'b0, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{"x",   1'b1, 1'b0, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{"T",   1'b1, 1'b1, 1'b1, 1'b1, ROW_TXT, FONT_MONO},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{"-",   1'b1, 1'b1, 1'b1, 1'b0, 5'd0,    FONT_SANS},
    '{"S",   1'b1, 1'b0, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{"w",   1'b1, 1'b0, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{"i",   1'b1, 1'b0, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{"s",   1'b1, 1'b0, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{"s",   1'b1, 1'b0, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{8'hA5, 1'b0, 1'b1, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{"0",   1'b1, 1'b0, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{"a",   1'b1, 1'b0, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{"z",   1'b1, 1'b0, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{"9",   1'b1, 1'b0, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{"Z",   1'b1, 1'b1, 1'b1, 1'b0, 5'd0,    FONT_SANS},
    '{"I",   1'b1, 1'b0, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{"S",   1'b1, 1'b0, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{"O",   1'b1, 1'b0, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{"C",   1'b1, 1'b0, 1'b0, 1'b0, 5'd0,    FONT_SANS},
    '{"P",   1'b1, 1'b1, 1'b1, 1'b1, ROW_ISOCP, FONT_SANS}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        char_code_i;
  logic              has_char_i;
  logic              last_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              found_o;
  logic [ROW_W-1:0]  row_index_o;
  logic [FONT_W-1:0] host_font_o;

  // Predictor state: newest kept character at index 0.
  logic [7:0]          name_tail [WINDOW_LEN];
  logic [NUM_ROWS-1:0] seen_rows;
  int unsigned         kept_len;

  match_t      pending_matches [$];
  int unsigned items_sent;
  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  font_name_pattern_matcher DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .has_char_i  (has_char_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .found_o     (found_o),
    .row_index_o (row_index_o),
    .host_font_o (host_font_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Receiver side: stall at random, per the current idle rate.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void clear_name();
    foreach (name_tail[i]) name_tail[i] = 8'h00;
    seen_rows = '0;
    kept_len  = 0;
  endfunction

  // Fold and filter one byte, respecting the key length cap, shift it into the
  // history, then mark every pattern that now ends at the newest character.
  function automatic void absorb_byte(input logic [7:0] code);
    logic [7:0]  c;
    int unsigned plen;
    bit          hit;
    c = code;
    if (kept_len >= KEPT_MAX) return;
    if (c >= "A" && c <= "Z") c = c + 8'h20;
    if (!((c >= "a" && c <= "z") || (c >= "0" && c <= "9"))) return;
    for (int i = WINDOW_LEN - 1; i > 0; i--) name_tail[i] = name_tail[i-1];
    name_tail[0] = c;
    kept_len++;
    for (int r = 0; r < NUM_ROWS; r++) begin
      plen = pat_text[r].len();
      if (plen <= kept_len && plen <= WINDOW_LEN) begin
        hit = 1'b1;
        for (int k = 0; k < plen; k++)
          if (8'(pat_text[r][plen-1-k]) != name_tail[k]) hit = 1'b0;
        if (hit) seen_rows[r] = 1'b1;
      end
    end
  endfunction

  // Advance the predictor by one request; a last request yields the lowest
  // seen row and restarts the name.
  function automatic void predict_match(input logic [7:0] code, input logic has,
                                        input logic lst, output bit emitted,
                                        output match_t res);
    res     = '0;
    emitted = lst;
    if (has) absorb_byte(code);
    if (!lst) return;
    for (int r = NUM_ROWS - 1; r >= 0; r--) begin
      if (seen_rows[r]) begin
        res.found = 1'b1;
        res.row   = ROW_W'(r);
        res.font  = PAT_FONT[r];
      end
    end
    clear_name();
  endfunction

  // Drive one request from a falling edge and hold it until accepted.
  task automatic send_request(input logic [7:0] code, input logic has, input logic lst,
                              input logic typed, input match_t typed_res);
    match_t res;
    bit     emitted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= code;
    has_char_i  <= has;
    last_i      <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    predict_match(code, has, lst, emitted, res);
    if (emitted) pending_matches = {pending_matches, (typed ? typed_res : res)};
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_case(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(1) == 1) return c - 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] rand_alnum();
    int unsigned pick;
    pick = $urandom_range(35);
    if (pick < 10) return 8'h30 + pick[7:0];
    return rand_case(8'h61 + pick[7:0] - 8'd10);
  endfunction

  // One random name. Mostly well-formed: pattern text in random case mixed
  // with filler, separators and byteless items; some patterns cut short,
  // some names past the key length, plus empty names and pure noise.
  task automatic send_random_name();
    logic [8:0]  reqs [$];
    int unsigned kind;
    int unsigned chunks;
    int unsigned r;
    int unsigned n;
    kind = $urandom_range(99);
    if (kind < 5) begin
      reqs = {reqs, {1'b0, 8'($urandom_range(255))}};
    end else if (kind < 12) begin
      n = $urandom_range(1, 12);
      repeat (n) reqs = {reqs, {1'($urandom_range(1)), 8'($urandom_range(255))}};
    end else begin
      // Overlong: patterns after the key limit must be ignored.
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(50, 70);
        repeat (n) reqs = {reqs, {1'b1, rand_alnum()}};
      end
      chunks = $urandom_range(1, 4);
      repeat (chunks) begin
        kind = $urandom_range(99);
        if (kind < 45) begin
          r = $urandom_range(NUM_ROWS - 1);
          n = pat_text[r].len();
          if ($urandom_range(4) == 0) n = n - $urandom_range(1, 2);
          for (int j = 0; j < n; j++)
            reqs = {reqs, {1'b1, rand_case(8'(pat_text[r][j]))}};
        end else if (kind < 70) begin
          n = $urandom_range(1, 5);
          repeat (n) reqs = {reqs, {1'b1, rand_alnum()}};
        end else if (kind < 85) begin
          reqs = {reqs, {1'b1, 8'($urandom_range(255))}};
        end else begin
          reqs = {reqs, {1'b0, 8'($urandom_range(255))}};
        end
      end
      if ($urandom_range(3) == 0) reqs = {reqs, {1'b0, 8'($urandom_range(255))}};
    end
    foreach (reqs[i])
      send_request(reqs[i][7:0], reqs[i][8], (i == reqs.size() - 1), 1'b0, '0);
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    match_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_matches.size() == 0) begin
        $error("unexpected result: found_o %0d row_index_o %0d host_font_o %0d",
               found_o, row_index_o, host_font_o);
        fail_count++;
      end else begin
        want = pending_matches.pop_front();
        if (found_o !== want.found) begin
          $error("found_o: expected %0d, got %0d", want.found, found_o);
          fail_count++;
        end
        if (row_index_o !== want.row) begin
          $error("row_index_o: expected %0d, got %0d", want.row, row_index_o);
          fail_count++;
        end
        if (host_font_o !== want.font) begin
          $error("host_font_o: expected %0d, got %0d", want.font, host_font_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    char_code_i   = 8'h00;
    has_char_i    = 1'b0;
    last_i        = 1'b0;
    items_sent    = 0;
    fail_count    = 0;
    send_idle_pct = 13;
    recv_idle_pct = 46;
    clear_name();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (PROBES[i])
      send_request(PROBES[i].code, PROBES[i].has, PROBES[i].lst, PROBES[i].typed,
                   '{PROBES[i].found, PROBES[i].row, PROBES[i].font});

    // Light sender, busy receiver; then the reverse; then back to back.
    while (items_sent < 340) send_random_name();
    send_idle_pct = 46;
    recv_idle_pct = 13;
    while (items_sent < 660) send_random_name();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (items_sent < 975) send_random_name();
    in_valid_i <= 1'b0;

    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("font_name_pattern_matcher: match");
    end else begin
      $display("font_name_pattern_matcher: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("font_name_pattern_matcher: mismatch");
    $finish;
  end

endmodule
